FILE: src/lerb_pkg.sv
package lerb_pkg;

    localparam logic [7:0] NL_BYTE    = 8'd10;
    localparam logic [7:0] SPACE_BYTE = 8'd32;

    typedef enum logic [1:0] {
        CMD_TYPE   = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NODEL  = 2'd2,
        ST_NOLINE = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] character;
        logic [7:0] max_bytes;
    } t_lerb_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data;
        logic       data_valid;
        logic [7:0] length;
        logic       last;
    } t_lerb_out;

    // Step addresses of the control program.
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] U_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] U_T0   = 4'd1;
    localparam logic [UPC_W-1:0] U_T1   = 4'd2;
    localparam logic [UPC_W-1:0] U_TF   = 4'd3;
    localparam logic [UPC_W-1:0] U_D0   = 4'd4;
    localparam logic [UPC_W-1:0] U_D1   = 4'd5;
    localparam logic [UPC_W-1:0] U_D2   = 4'd6;
    localparam logic [UPC_W-1:0] U_DF   = 4'd7;
    localparam logic [UPC_W-1:0] U_R0   = 4'd8;
    localparam logic [UPC_W-1:0] U_R1   = 4'd9;
    localparam logic [UPC_W-1:0] U_R2   = 4'd10;
    localparam logic [UPC_W-1:0] U_R3   = 4'd11;
    localparam logic [UPC_W-1:0] U_R4   = 4'd12;
    localparam logic [UPC_W-1:0] U_RD   = 4'd13;
    localparam logic [UPC_W-1:0] U_RN   = 4'd14;
    localparam logic [UPC_W-1:0] U_RC   = 4'd15;

    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_FULL, C_NL, C_CAP, C_NOLINE
    } t_cond;

    typedef enum logic [1:0] {
        A_WR, A_WR_PREV, A_RM_NEXT
    } t_asel;

    typedef enum logic [1:0] {
        WE_NONE, WE_CH, WE_CH_NL, WE_SPACE
    } t_we;

    typedef enum logic [1:0] {
        WR_HOLD, WR_INC, WR_DEC, WR_INC_IF_MEET
    } t_wrop;

    typedef enum logic [1:0] {
        CNT_HOLD, CNT_INC_IF_NL, CNT_DEC
    } t_cntop;

    typedef enum logic [1:0] {
        N_HOLD, N_CLR, N_INC
    } t_nop;

    typedef enum logic [2:0] {
        EM_NONE, EM_ECHO_CH, EM_ECHO_SP, EM_BYTE, EM_END,
        EM_FULL, EM_NODEL, EM_NOLINE
    } t_emit;

    typedef struct packed {
        t_cond            cond;
        logic [UPC_W-1:0] target;
        t_asel            addr;
        logic             rd;
        t_we              we;
        t_wrop            wr;
        logic             rm_inc;
        t_cntop           cnt;
        t_nop             n;
        t_emit            emit;
    } t_lerb_uword;

    typedef struct packed {
        logic full;
        logic nl;
        logic cap;
        logic noline;
    } t_lerb_flags;

    function automatic t_lerb_uword lerb_rom(input logic [UPC_W-1:0] upc);
        t_lerb_uword w;
        w = '{cond: C_NEXT, target: U_IDLE, addr: A_WR, rd: 1'b0, we: WE_NONE,
              wr: WR_HOLD, rm_inc: 1'b0, cnt: CNT_HOLD, n: N_HOLD, emit: EM_NONE};
        case (upc)
            U_T0: begin
                // A newline is stored and counted even when the ring turns out full.
                w.we = WE_CH_NL;
                w.cnt = CNT_INC_IF_NL;
                w.cond = C_FULL;
                w.target = U_TF;
            end
            U_T1: begin
                w.we = WE_CH;
                w.wr = WR_INC;
                w.emit = EM_ECHO_CH;
                w.cond = C_ALWAYS;
            end
            U_TF: begin
                w.emit = EM_FULL;
                w.cond = C_ALWAYS;
            end
            U_D0: begin
                w.addr = A_WR_PREV;
                w.rd = 1'b1;
            end
            U_D1: begin
                w.cond = C_NL;
                w.target = U_DF;
            end
            U_D2: begin
                w.addr = A_WR_PREV;
                w.we = WE_SPACE;
                w.wr = WR_DEC;
                w.emit = EM_ECHO_SP;
                w.cond = C_ALWAYS;
            end
            U_DF: begin
                w.emit = EM_NODEL;
                w.cond = C_ALWAYS;
            end
            U_R0: begin
                w.cond = C_NOLINE;
                w.target = U_RN;
            end
            U_R1: begin
                w.addr = A_RM_NEXT;
                w.rd = 1'b1;
                w.rm_inc = 1'b1;
                w.n = N_CLR;
            end
            U_R2: begin
                w.cond = C_NL;
                w.target = U_RD;
            end
            U_R3: begin
                w.cond = C_CAP;
                w.target = U_RC;
            end
            U_R4: begin
                w.emit = EM_BYTE;
                w.n = N_INC;
                w.rm_inc = 1'b1;
                w.addr = A_RM_NEXT;
                w.rd = 1'b1;
                w.cond = C_ALWAYS;
                w.target = U_R2;
            end
            U_RD: begin
                w.wr = WR_INC_IF_MEET;
                w.cnt = CNT_DEC;
                w.emit = EM_END;
                w.cond = C_ALWAYS;
            end
            U_RN: begin
                w.emit = EM_NOLINE;
                w.cond = C_ALWAYS;
            end
            U_RC: begin
                w.emit = EM_END;
                w.cond = C_ALWAYS;
            end
            default: begin
                w.cond = C_ALWAYS;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: src/lerb_seq.sv
module lerb_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_command,
    input  lerb_pkg::t_lerb_flags i_flags,
    output lerb_pkg::t_lerb_uword o_uword,
    output logic                 o_busy
);
    import lerb_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    logic [UPC_W-1:0] upc_inc;
    t_lerb_uword      uw;
    logic             take;

    assign uw      = lerb_rom(r_upc);
    assign upc_inc = r_upc + UPC_W'(1);

    always_comb begin
        case (uw.cond)
            C_ALWAYS: take = 1'b1;
            C_FULL:   take = i_flags.full;
            C_NL:     take = i_flags.nl;
            C_CAP:    take = i_flags.cap;
            C_NOLINE: take = i_flags.noline;
            default:  take = 1'b0;
        endcase
    end

    always_comb begin
        if (r_upc == U_IDLE) begin
            n_upc = U_IDLE;
            if (i_accept) begin
                case (t_cmd'(i_command))
                    CMD_TYPE:   n_upc = U_T0;
                    CMD_DELETE: n_upc = U_D0;
                    CMD_READ:   n_upc = U_R0;
                    default:    n_upc = U_IDLE;
                endcase
            end
        end else begin
            n_upc = take ? uw.target : upc_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = uw;
    assign o_busy  = (r_upc != U_IDLE);

endmodule

FILE: src/lerb_dp.sv
module lerb_dp #(
    parameter int DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  lerb_pkg::t_lerb_in    i_in,
    input  lerb_pkg::t_lerb_uword i_uword,
    output lerb_pkg::t_lerb_flags o_flags,
    output logic                  o_strobe,
    output lerb_pkg::t_lerb_out   o_result
);
    import lerb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX   = CW'(DEPTH);
    localparam logic [7:0]    RUN_MAX   = 8'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_mem_q;
    logic          r_force;
    logic          r_slot0_set;
    t_lerb_in      r_in;
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rm;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_n;
    logic          r_strobe, n_strobe;
    t_lerb_out     r_out, n_out;

    logic [AW-1:0] addr;
    logic [7:0]    wdata;
    logic          we_en;
    logic [7:0]    rdata;
    logic          ch_is_nl;

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST_SLOT : i - AW'(1);
    endfunction

    assign ch_is_nl = (r_in.character == NL_BYTE);
    // Slot 0 reads as a newline until it is first written after reset.
    assign rdata    = r_force ? NL_BYTE : r_mem_q;

    always_comb begin
        case (i_uword.addr)
            A_WR_PREV: addr = slot_prev(r_wr);
            A_RM_NEXT: addr = slot_next(r_rm);
            default:   addr = r_wr;
        endcase
        case (i_uword.we)
            WE_CH:    we_en = 1'b1;
            WE_CH_NL: we_en = ch_is_nl;
            WE_SPACE: we_en = 1'b1;
            default:  we_en = 1'b0;
        endcase
        wdata = (i_uword.we == WE_SPACE) ? SPACE_BYTE : r_in.character;
    end

    assign o_flags.full   = (r_rm == r_wr);
    assign o_flags.nl     = (rdata == NL_BYTE);
    assign o_flags.cap    = (r_n == r_in.max_bytes) || (r_n >= RUN_MAX);
    assign o_flags.noline = (r_cnt == '0);

    always_comb begin
        case (i_uword.wr)
            WR_INC:         n_wr = slot_next(r_wr);
            WR_DEC:         n_wr = slot_prev(r_wr);
            WR_INC_IF_MEET: n_wr = (r_rm == r_wr) ? slot_next(r_wr) : r_wr;
            default:        n_wr = r_wr;
        endcase
        case (i_uword.cnt)
            CNT_INC_IF_NL: n_cnt = (ch_is_nl && r_cnt != CNT_MAX) ? r_cnt + CW'(1) : r_cnt;
            CNT_DEC:       n_cnt = r_cnt - CW'(1);
            default:       n_cnt = r_cnt;
        endcase
    end

    always_comb begin
        n_out    = '0;
        n_strobe = 1'b1;
        case (i_uword.emit)
            EM_ECHO_CH: begin
                n_out.data       = r_in.character;
                n_out.data_valid = 1'b1;
                n_out.last       = 1'b1;
            end
            EM_ECHO_SP: begin
                n_out.data       = SPACE_BYTE;
                n_out.data_valid = 1'b1;
                n_out.last       = 1'b1;
            end
            EM_BYTE: begin
                n_out.data       = rdata;
                n_out.data_valid = 1'b1;
            end
            EM_END: begin
                n_out.length = r_n;
                n_out.last   = 1'b1;
            end
            EM_FULL: begin
                n_out.status = ST_FULL;
                n_out.last   = 1'b1;
            end
            EM_NODEL: begin
                n_out.status = ST_NODEL;
                n_out.last   = 1'b1;
            end
            EM_NOLINE: begin
                n_out.status = ST_NOLINE;
                n_out.last   = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_en) begin
            mem[addr] <= wdata;
        end
        if (i_uword.rd) begin
            r_mem_q <= mem[addr];
            r_force <= (addr == '0) && !r_slot0_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in <= i_in;
        end
        case (i_uword.n)
            N_CLR:   r_n <= '0;
            N_INC:   r_n <= r_n + 8'd1;
            default: r_n <= r_n;
        endcase
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= AW'(1);
            r_rm        <= '0;
            r_cnt       <= '0;
            r_slot0_set <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_wr     <= n_wr;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
            if (i_uword.rm_inc) begin
                r_rm <= slot_next(r_rm);
            end
            if (we_en && addr == '0) begin
                r_slot0_set <= 1'b1;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("line count above ring depth");

    a_dec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_uword.cnt == CNT_DEC |-> r_cnt != '0)
        else $error("line count decremented at zero");

    a_rm_moves_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_uword.rm_inc |-> i_uword.rd && i_uword.addr == A_RM_NEXT)
        else $error("read mark advanced without a matching fetch");

endmodule

FILE: src/line_edit_ring_buffer.sv
// Line-edit ring buffer: keyboard lines kept in a ring of DEPTH byte slots.
// Input channel: drive i_in and raise start; the transaction is taken at the
// rising edge where start is high and busy is low. Command 0 stores and echoes
// a character, command 1 erases the previous character, command 2 returns the
// oldest complete line byte by byte and then an end result with its length.
// Command 3 is dropped without any result.
// Output channel: each result sits on o_result for exactly one cycle with
// o_strobe high; the receiver must take it then, as it cannot stall the block.
// Timing: a small control program steps one word per cycle. A type command
// checks for a full ring, then stores and echoes its character (else reports
// full); a delete fetches the prior character, then erases it (else reports
// no delete at a newline). Each has a single result. Busy falls in the cycle
// that shows the final result, so the next transaction can be taken at the
// edge that ends it. A read checks for a waiting line (else reports no line)
// and fetches the first byte, then per byte tests for newline and cap, emits
// and fetches; the end result follows the newline test, or the cap test.
// The ring memory has one port with a registered read, which sets the byte
// rate. Reset (synchronous, active low) empties the ring at once: it then
// holds only the delimiter in slot 0; no clearing pass is needed.
module line_edit_ring_buffer #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lerb_pkg::t_lerb_in  i_in,
    output logic                o_strobe,
    output lerb_pkg::t_lerb_out o_result
);
    import lerb_pkg::*;

    logic        accept;
    t_lerb_uword uword;
    t_lerb_flags flags;

    assign accept = start && !busy;

    lerb_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_in.command),
        .i_flags   (flags),
        .o_uword   (uword),
        .o_busy    (busy)
    );

    lerb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .i_uword  (uword),
        .o_flags  (flags),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_quiet_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_strobe)
        else $error("result shown right after a new transaction");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> !busy)
        else $error("still busy while final result is shown");

    a_more_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("idle before the final result of a read");

endmodule
